// ===== rtl/solmf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package solmf_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // priority encoder grouping
  localparam int GRP = 8;
  localparam int GRP_W = $clog2(GRP);
  localparam int NGRP = (DEPTH + GRP - 1) / GRP;
  localparam int NGRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;

  localparam int DIST_W = 7;
  localparam int POS_W = 7;
  // common width for distance arithmetic
  localparam int DW = (IDX_W > DIST_W) ? IDX_W : DIST_W;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] value;
    logic [DIST_W-1:0]  move_distance;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] position;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_GROUP,
    S_SELECT,
    S_UPDATE
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/solmf_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module solmf_cell
  import solmf_pkg::*;
(
  input  wire logic        clk,
  input  wire cell_ctl_t   ctl,
  input  wire logic [31:0] load_value,
  input  wire logic [31:0] left_value,
  input  wire logic [31:0] key,
  output logic [31:0]      entry,
  output logic             match
);

  logic [31:0] entry_r;
  logic        match_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry_r <= load_value;
    end else if (ctl.shift) begin
      entry_r <= left_value;
    end
    match_r <= (entry_r == key);
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule
`default_nettype wire

// ===== rtl/solmf_prio.sv =====
`timescale 1ns / 1ps
`default_nettype none
module solmf_prio
  import solmf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [DEPTH-1:0] hit,
  output logic                  found,
  output logic [IDX_W-1:0]      index
);

  logic [NGRP*GRP-1:0] hit_pad;
  logic [NGRP-1:0]     grp_hit_r, grp_hit_nxt;
  logic [GRP_W-1:0]    grp_loc_r [NGRP];
  logic [GRP_W-1:0]    grp_loc_nxt [NGRP];
  logic                found_r, found_nxt;
  logic [IDX_W-1:0]    index_r, index_nxt;
  logic [NGRP_W+GRP_W-1:0] wide_idx;

  assign hit_pad = (NGRP*GRP)'(hit);

  // first stage: first hit within each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_hit_nxt[g] = |hit_pad[g*GRP +: GRP];
      grp_loc_nxt[g] = '0;
      for (int k = GRP - 1; k >= 0; k--) begin
        if (hit_pad[g*GRP + k]) begin
          grp_loc_nxt[g] = GRP_W'(k);
        end
      end
    end
  end

  // second stage: first group with a hit
  always_comb begin
    wide_idx = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_hit_r[g]) begin
        wide_idx = {NGRP_W'(g), grp_loc_r[g]};
      end
    end
    found_nxt = |grp_hit_r;
    index_nxt = wide_idx[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    grp_hit_r <= grp_hit_nxt;
    grp_loc_r <= grp_loc_nxt;
    found_r   <= found_nxt;
    index_r   <= index_nxt;
  end

  assign found = found_r;
  assign index = index_r;

endmodule
`default_nettype wire

// ===== rtl/self_organizing_list_move_forward.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Self-organising list with move-ahead-by-k: a row of DEPTH cells, each holding one
// 32-bit entry, with the front of the list in cell 0. Every transfer in yields one
// result. Clear, append and unused modes go straight from acceptance to the update
// step that registers the result. A search first registers the compare in every
// cell, then passes the S_GROUP and S_SELECT steps through the registered priority
// encoder that finds the first match, and then the update step, in which each cell
// between destination and hit takes its left neighbour's entry.
// A stalled result holds the block in its final step; the next item can be accepted
// in the cycle after the result is registered.
module self_organizing_list_move_forward
  import solmf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  state_t     state_r, state_nxt;
  in_item_t   item_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;

  logic       in_fire;
  logic       upd_fire;

  logic [31:0]      cell_entry [DEPTH];
  logic [DEPTH-1:0] cell_match;
  logic [DEPTH-1:0] hit;
  cell_ctl_t        cell_ctl [DEPTH];

  logic             found;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] dst_idx;
  logic [DW-1:0]    idx_ext, dist_ext;
  logic             full;
  logic             do_search, do_append;

  assign in_fire = in_valid && in_ready;
  assign full = (count_r == CNT_W'(DEPTH));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_data.mode == MODE_SEARCH) ? S_MATCH : S_UPDATE;
        end
      end
      S_MATCH:  state_nxt = S_GROUP;
      S_GROUP:  state_nxt = S_SELECT;
      S_SELECT: state_nxt = S_UPDATE;
      S_UPDATE: begin
        if (upd_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready = 1'b0;
    upd_fire = 1'b0;
    unique case (state_r)
      S_IDLE:   in_ready = 1'b1;
      S_UPDATE: upd_fire = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
        upd_fire = 1'b0;
      end
    endcase
  end

  assign do_search = upd_fire && (item_r.mode == MODE_SEARCH) && found;
  assign do_append = upd_fire && (item_r.mode == MODE_APPEND) && !full;

  assign idx_ext  = DW'(hit_idx);
  assign dist_ext = DW'(item_r.move_distance);
  assign dst_idx  = (dist_ext >= idx_ext) ? '0 : IDX_W'(idx_ext - dist_ext);

  // per-cell control: shift the passed entries back, drop the value into place
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      cell_ctl[j].shift = do_search && (IDX_W'(j) > dst_idx) && (IDX_W'(j) <= hit_idx);
      cell_ctl[j].load  = (do_search && (IDX_W'(j) == dst_idx))
                       || (do_append && (CNT_W'(j) == count_r));
      hit[j] = cell_match[j] && (CNT_W'(j) < count_r);
    end
  end

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic [31:0] left;
    if (j == 0) begin : g_front
      assign left = '0;
    end else begin : g_rest
      assign left = cell_entry[j-1];
    end
    solmf_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[j]),
      .load_value (item_r.value),
      .left_value (left),
      .key        (item_r.value),
      .entry      (cell_entry[j]),
      .match      (cell_match[j])
    );
  end

  solmf_prio u_prio (
    .clk   (clk),
    .hit   (hit),
    .found (found),
    .index (hit_idx)
  );

  // result and list length
  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (upd_fire) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.status   = ST_OK;
      out_data_nxt.position = '0;
      case (item_r.mode)
        MODE_CLEAR: count_nxt = '0;
        MODE_APPEND: begin
          if (full) begin
            out_data_nxt.status = ST_FULL;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        MODE_SEARCH: begin
          if (found) begin
            out_data_nxt.position = POS_W'(DW'(hit_idx) + DW'(1));
          end else begin
            out_data_nxt.status = ST_NOT_FOUND;
          end
        end
        default: count_nxt = count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/solmf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module solmf_checker
  import solmf_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_NOT_FOUND
                   || out_data.status == ST_FULL))
    else $error("unknown status code");

  a_pos_only_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.position == '0)
    else $error("position reported without a hit");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // drop ready once an item is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer accepted while busy");

endmodule

bind self_organizing_list_move_forward solmf_checker u_solmf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// ===== dv/solmf_list_checker.sv =====
`timescale 1ns / 1ps
module solmf_list_checker
  import solmf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  output int unsigned pending_results,
  output int unsigned fail_count
);

  localparam int PRINT_CAP = 50;

  // shadow copy of the list, front at index 0
  logic signed [31:0] shadow_list [DEPTH];
  int unsigned        shadow_len;
  out_item_t          expected_results [$];

  initial begin
    pending_results = 0;
    fail_count      = 0;
    shadow_len      = 0;
  end

  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_CAP) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
    fail_count++;
  endtask

  // apply one operation to the shadow list and return the result it gives
  function automatic out_item_t apply_list_op(input in_item_t op);
    out_item_t res;
    int        hit_idx;
    int        dst;
    res.status   = ST_OK;
    res.position = '0;
    case (op.mode)
      MODE_CLEAR: begin
        shadow_len = 0;
      end
      MODE_APPEND: begin
        if (shadow_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_list[shadow_len] = op.value;
          shadow_len++;
        end
      end
      MODE_SEARCH: begin
        hit_idx = -1;
        for (int i = 0; i < int'(shadow_len); i++) begin
          if (hit_idx < 0 && shadow_list[i] == op.value) hit_idx = i;
        end
        if (hit_idx < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.position = POS_W'(hit_idx + 1);
          dst = (int'(op.move_distance) >= hit_idx) ? 0 : hit_idx - int'(op.move_distance);
          // entries passed over each shift back by one place
          for (int j = hit_idx; j > dst; j--) shadow_list[j] = shadow_list[j-1];
          shadow_list[dst] = op.value;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      shadow_len = 0;
      expected_results.delete();
    end else begin
      // a result never comes out in the same cycle as its transfer in, so check first
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status=%0d position=%0d",
                                    out_data.status, out_data.position));
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_data.status, want.status));
          if (out_data.position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      out_data.position, want.position));
        end
      end
      if (in_valid && in_ready) expected_results.push_back(apply_list_op(in_data));
    end
    pending_results = expected_results.size();
  end

endmodule

// ===== dv/tb_self_organizing_list_move_forward.sv =====
`timescale 1ns / 1ps
module tb_self_organizing_list_move_forward;
  import solmf_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 125;
  localparam int POOL_SIZE   = 16;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int unsigned pending_results;
  int unsigned fail_count;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned ops_sent = 0;
  logic signed [31:0] value_pool [POOL_SIZE];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  self_organizing_list_move_forward u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  solmf_list_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .pending_results (pending_results),
    .fail_count      (fail_count)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic in_item_t list_op(input logic [1:0] mode, input logic signed [31:0] value,
                                       input logic [DIST_W-1:0] move_dist);
    in_item_t op;
    op.mode          = mode;
    op.value         = value;
    op.move_distance = move_dist;
    return op;
  endfunction

  function automatic logic signed [31:0] pick_value(input int unsigned pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return value_pool[$urandom_range(0, POOL_SIZE-1)];
    return $urandom;
  endfunction

  function automatic logic [DIST_W-1:0] pick_distance();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return DIST_W'(1);
      2: return DIST_W'($urandom_range(2, 8));
      3: return DIST_W'($urandom_range(0, 64));
      4: return DIST_W'($urandom_range(65, 127));
      default: return DIST_W'($urandom_range(0, 127));
    endcase
  endfunction

  // called and returns at a falling edge; valid is held until the transfer
  task automatic issue_op(input in_item_t op);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op.mode != MODE_UNUSED) ops_sent++;
    @(negedge clk);
  endtask

  task automatic fill_list(input int unsigned count, input bit start_clear);
    if (start_clear) issue_op(list_op(MODE_CLEAR, $urandom, DIST_W'($urandom)));
    repeat (count) issue_op(list_op(MODE_APPEND, pick_value(85), DIST_W'($urandom)));
  endtask

  task automatic search_burst(input int unsigned count);
    repeat (count) issue_op(list_op(MODE_SEARCH, pick_value(85), pick_distance()));
  endtask

  task automatic run_random_bursts(input int unsigned quota);
    int unsigned target;
    target = ops_sent + quota;
    while (ops_sent < target) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          if ($urandom_range(0, 2) == 0)
            fill_list($urandom_range(60, 70), 1'($urandom_range(0, 1)));
          else fill_list($urandom_range(1, 20), $urandom_range(0, 3) == 0);
        end
        8: begin
          // noise: any mode, arbitrary content
          repeat ($urandom_range(1, 4))
            issue_op(list_op(2'($urandom_range(0, 3)), pick_value(30), DIST_W'($urandom)));
        end
        9: begin
          fill_list($urandom_range(1, 3), 1'b0);
          search_burst($urandom_range(1, 3));
        end
        default: search_burst($urandom_range(3, 12));
      endcase
    end
  endtask

  initial begin
    value_pool[0] = 32'sh7fffffff;
    value_pool[1] = 32'sh80000000;
    value_pool[2] = -32'sd1;
    value_pool[3] = 32'sd0;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty list, unused mode, extremes, moves of every reach, duplicates
    issue_op(list_op(MODE_SEARCH, 32'sd42, 7'd3));
    issue_op(list_op(MODE_UNUSED, 32'sh5a5a5a5a, 7'h7f));
    issue_op(list_op(MODE_APPEND, 32'sh7fffffff, 7'd0));
    issue_op(list_op(MODE_APPEND, 32'sh80000000, 7'd0));
    issue_op(list_op(MODE_APPEND, -32'sd1, 7'd0));
    issue_op(list_op(MODE_APPEND, 32'sd0, 7'd0));
    issue_op(list_op(MODE_APPEND, 32'sd5, 7'd0));
    issue_op(list_op(MODE_APPEND, -32'sd1, 7'd0));
    issue_op(list_op(MODE_SEARCH, 32'sd5, 7'd0));
    issue_op(list_op(MODE_SEARCH, 32'sd5, 7'd1));
    issue_op(list_op(MODE_SEARCH, 32'sd5, 7'd127));
    issue_op(list_op(MODE_SEARCH, 32'sd0, 7'd4));
    issue_op(list_op(MODE_SEARCH, -32'sd1, 7'd1));
    issue_op(list_op(MODE_SEARCH, 32'sh80000000, 7'd64));
    issue_op(list_op(MODE_SEARCH, 32'sh7fffffff, 7'd2));
    issue_op(list_op(MODE_SEARCH, 32'sd12345, 7'd1));
    issue_op(list_op(MODE_CLEAR, 32'sd0, 7'd0));
    issue_op(list_op(MODE_SEARCH, -32'sd1, 7'd1));
    issue_op(list_op(MODE_APPEND, -32'sd1, 7'd0));
    issue_op(list_op(MODE_SEARCH, -32'sd1, 7'd1));

    // no idling; start by running the list past full
    fill_list(66, 1'b1);
    search_burst(10);
    run_random_bursts(PHASE_ITEMS - 77);

    send_idle_pct  = 51;
    recv_stall_pct = 0;
    run_random_bursts(PHASE_ITEMS);

    send_idle_pct  = 0;
    recv_stall_pct = 51;
    run_random_bursts(PHASE_ITEMS);

    send_idle_pct  = 10;
    recv_stall_pct = 10;
    run_random_bursts(PHASE_ITEMS);

    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("self_organizing_list_move_forward regression: pass");
    end else begin
      $display("self_organizing_list_move_forward regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("self_organizing_list_move_forward regression: fail");
    $finish;
  end

endmodule
